>>> sv/ctsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctsc_pkg;

  localparam logic [15:0] DebounceResetMs = 16'd300;
  localparam logic [4:0]  HourMax         = 5'd23;
  localparam logic [5:0]  MinuteMax       = 6'd59;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_HOURS   = 2'd1,
    MODE_MINUTES = 2'd2
  } ctsc_mode_e;

  // Control results of one tick, handed from the control unit to the display.
  typedef struct packed {
    ctsc_mode_e mode;
    logic [4:0] edit_hour;
    logic [5:0] edit_minute;
    logic       wr;
    logic [4:0] wh;
    logic [5:0] wm;
  } ctsc_upd_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] units;
  } ctsc_bcd_t;

  // Tens and units of a 6-bit value, by compare against the multiples of ten.
  function automatic ctsc_bcd_t split_dec(input logic [5:0] v);
    ctsc_bcd_t r;
    r.tens  = 3'd0;
    r.units = v[3:0];
    for (int i = 1; i <= 6; i++) begin
      if (v >= 6'(10 * i)) begin
        r.tens  = 3'(i);
        r.units = 4'(v - 6'(10 * i));
      end
    end
    return r;
  endfunction

  // Segment pattern, bit0 = A .. bit6 = G.
  function automatic logic [6:0] seg_encode(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> sv/ctsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ctsc_ctrl
  import ctsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [4:0]  hour_i,
  input  wire logic [5:0]  minute_i,
  input  wire logic        set_i,
  input  wire logic        up_i,
  input  wire logic        down_i,
  input  wire logic [15:0] debounce_i,
  output ctsc_upd_t        upd_o
);

  ctsc_mode_e  mode_q, mode_d;
  logic [31:0] last_q, last_d;
  logic        loaded_q;
  logic [4:0]  edit_hour_q, hour_base, hour_d;
  logic [5:0]  edit_minute_q, minute_base, minute_d;
  logic [31:0] elapsed;
  logic        pass, set_acc, up_acc, down_acc, editing;
  logic        wr;
  logic [4:0]  wh;
  logic [5:0]  wm;

  // Edit values load from the clock on the first tick after reset.
  assign hour_base   = loaded_q ? edit_hour_q : hour_i;
  assign minute_base = loaded_q ? edit_minute_q : minute_i;

  // One shared gate, timed from the last accepted press; set has priority over up,
  // and up over down, so at most one button acts per tick.
  assign elapsed = now_ms_i - last_q;
  assign pass    = elapsed > {16'd0, debounce_i};
  assign set_acc = set_i & pass;

  always_comb begin
    mode_d = mode_q;
    wr     = 1'b0;
    wh     = '0;
    wm     = '0;
    if (set_acc) begin
      unique case (mode_q)
        MODE_NORMAL: mode_d = MODE_HOURS;
        MODE_HOURS: begin
          mode_d = MODE_MINUTES;
          wr     = 1'b1;
          wh     = hour_base;
          wm     = minute_i;
        end
        default: begin
          mode_d = MODE_NORMAL;
          wr     = 1'b1;
          wh     = hour_i;
          wm     = minute_base;
        end
      endcase
    end
  end

  assign editing  = (mode_d == MODE_HOURS) || (mode_d == MODE_MINUTES);
  assign up_acc   = pass & ~set_acc & up_i & editing;
  assign down_acc = pass & ~set_acc & ~up_i & down_i & editing;
  assign last_d   = (set_acc | up_acc | down_acc) ? now_ms_i : last_q;

  always_comb begin
    hour_d   = hour_base;
    minute_d = minute_base;
    if (mode_d == MODE_HOURS) begin
      if (up_acc) begin
        hour_d = (hour_base >= HourMax) ? 5'd0 : hour_base + 5'd1;
      end else if (down_acc) begin
        hour_d = (hour_base == 5'd0) ? HourMax : hour_base - 5'd1;
      end
    end else if (mode_d == MODE_MINUTES) begin
      if (up_acc) begin
        minute_d = (minute_base >= MinuteMax) ? 6'd0 : minute_base + 6'd1;
      end else if (down_acc) begin
        minute_d = (minute_base == 6'd0) ? MinuteMax : minute_base - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NORMAL;
      last_q   <= '0;
      loaded_q <= 1'b0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      last_q   <= last_d;
      loaded_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      edit_hour_q   <= hour_d;
      edit_minute_q <= minute_d;
    end
  end

  always_comb begin
    upd_o.mode        = mode_d;
    upd_o.edit_hour   = hour_d;
    upd_o.edit_minute = minute_d;
    upd_o.wr          = wr;
    upd_o.wh          = wh;
    upd_o.wm          = wm;
  end

endmodule

`default_nettype wire

>>> sv/ctsc_disp.sv
`timescale 1ns / 1ps
`default_nettype none

module ctsc_disp
  import ctsc_pkg::*;
(
  input  wire logic [4:0] hour_i,
  input  wire logic [5:0] minute_i,
  input  wire logic       sec_odd_i,
  input  ctsc_upd_t       upd_i,
  output logic      [6:0] seg0_o,
  output logic      [6:0] seg1_o,
  output logic      [6:0] seg2_o,
  output logic      [6:0] seg3_o,
  output logic            colon_o
);

  logic [5:0] hour_show, minute_show;
  ctsc_bcd_t  hour_bcd, minute_bcd;
  logic       blink;

  assign hour_show   = (upd_i.mode == MODE_HOURS) ? {1'b0, upd_i.edit_hour} : {1'b0, hour_i};
  assign minute_show = (upd_i.mode == MODE_MINUTES) ? upd_i.edit_minute : minute_i;
  assign hour_bcd    = split_dec(hour_show);
  assign minute_bcd  = split_dec(minute_show);

  // Even second: colon lit, edited field blanked.
  assign blink   = ~sec_odd_i;
  assign colon_o = blink;

  always_comb begin
    seg0_o = seg_encode({1'b0, hour_bcd.tens});
    seg1_o = seg_encode(hour_bcd.units);
    seg2_o = seg_encode({1'b0, minute_bcd.tens});
    seg3_o = seg_encode(minute_bcd.units);
    if (blink && upd_i.mode == MODE_HOURS) begin
      seg0_o = '0;
      seg1_o = '0;
    end
    if (blink && upd_i.mode == MODE_MINUTES) begin
      seg2_o = '0;
      seg3_o = '0;
    end
  end

endmodule

`default_nettype wire

>>> sv/clock_time_set_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Clock time-set controller: button debounce, set-mode sequencing, 4-digit display.
// A tick is held in the input register, then its result in the output register.
// Throughput: one tick per cycle unless the output stalls; state update and display
//   decode sit in one combinational pass between the input and output registers.
// Reset (rst_ni low, async): pipeline empty, mode normal, last press time 0,
//   debounce 300 ms, edit values reloaded from the first tick after reset.

module clock_time_set_controller_core
  import ctsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  // tick input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [4:0]  clock_hour_i,
  input  wire logic [5:0]  clock_minute_i,
  input  wire logic [5:0]  clock_second_i,
  input  wire logic        set_button_i,
  input  wire logic        up_button_i,
  input  wire logic        down_button_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [6:0]  seg_digit0_o,
  output logic      [6:0]  seg_digit1_o,
  output logic      [6:0]  seg_digit2_o,
  output logic      [6:0]  seg_digit3_o,
  output logic             colon_on_o,
  output logic             clock_write_o,
  output logic      [4:0]  write_hour_o,
  output logic      [5:0]  write_minute_o,
  output logic      [1:0]  mode_now_o
);

  // Debounce register; writes are always accepted.
  logic [15:0] debounce_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceResetMs;
    end else if (cfg_valid_i) begin
      debounce_q <= cfg_data_i;
    end
  end

  // Input register stage.
  logic        s1_valid_q;
  logic [31:0] s1_now_q;
  logic [4:0]  s1_hour_q;
  logic [5:0]  s1_minute_q;
  logic        s1_sec_odd_q;
  logic        s1_set_q, s1_up_q, s1_down_q;

  logic out_valid_q;
  logic out_free;   // output register can take a new result this cycle
  logic fire;       // s1 item is processed and moves to the output register
  logic in_take;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign fire       = s1_valid_q & out_free;
  assign in_stall_o = s1_valid_q & ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Only the second's parity matters for the display.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_now_q     <= now_ms_i;
      s1_hour_q    <= clock_hour_i;
      s1_minute_q  <= clock_minute_i;
      s1_sec_odd_q <= clock_second_i[0];
      s1_set_q     <= set_button_i;
      s1_up_q      <= up_button_i;
      s1_down_q    <= down_button_i;
    end
  end

  // Mode / edit state and the debounce gate; state commits on fire.
  ctsc_upd_t upd;

  ctsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .now_ms_i   (s1_now_q),
    .hour_i     (s1_hour_q),
    .minute_i   (s1_minute_q),
    .set_i      (s1_set_q),
    .up_i       (s1_up_q),
    .down_i     (s1_down_q),
    .debounce_i (debounce_q),
    .upd_o      (upd)
  );

  // Digit decode and blanking.
  logic [6:0] seg0, seg1, seg2, seg3;
  logic       colon;

  ctsc_disp u_disp (
    .hour_i    (s1_hour_q),
    .minute_i  (s1_minute_q),
    .sec_odd_i (s1_sec_odd_q),
    .upd_i     (upd),
    .seg0_o    (seg0),
    .seg1_o    (seg1),
    .seg2_o    (seg2),
    .seg3_o    (seg3),
    .colon_o   (colon)
  );

  // Output register: holds a result under stall; s1 stalls once it holds a tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      seg_digit0_o   <= seg0;
      seg_digit1_o   <= seg1;
      seg_digit2_o   <= seg2;
      seg_digit3_o   <= seg3;
      colon_on_o     <= colon;
      clock_write_o  <= upd.wr;
      write_hour_o   <= upd.wh;
      write_minute_o <= upd.wm;
      mode_now_o     <= upd.mode;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> sv/ctsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ctsc_checker
  import ctsc_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [6:0] seg_digit0_o,
  input wire logic [6:0] seg_digit1_o,
  input wire logic [6:0] seg_digit2_o,
  input wire logic [6:0] seg_digit3_o,
  input wire logic       colon_on_o,
  input wire logic       clock_write_o,
  input wire logic [4:0] write_hour_o,
  input wire logic [5:0] write_minute_o,
  input wire logic [1:0] mode_now_o
);

  // A stalled result transfer holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_now_o)
      && $stable(clock_write_o) && $stable(seg_digit0_o) && $stable(seg_digit3_o))
    else $error("result changed under stall");

  // A clock write only happens when leaving a set mode.
  a_write_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clock_write_o |-> mode_now_o != MODE_HOURS)
    else $error("clock write while entering hour set");

  // Write fields are zero without a write.
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !clock_write_o |-> write_hour_o == 5'd0 && write_minute_o == 6'd0)
    else $error("write fields set without clock write");

  // Blink: in hour set with the colon lit, the hour digits are blank, minute tens not.
  a_blink_hours: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && colon_on_o && mode_now_o == MODE_HOURS
      |-> seg_digit0_o == 7'd0 && seg_digit1_o == 7'd0 && seg_digit2_o != 7'd0)
    else $error("hour field not blanked");

endmodule

bind clock_time_set_controller_core ctsc_checker u_ctsc_checker (.*);

`default_nettype wire
